[design/hte_pkg.sv]
// constants, character tables and helper functions shared by the text extractor
`timescale 1ns / 1ps

package hte_pkg;

    typedef logic [7:0] char_t;

    // width of the output cap register
    localparam int MAX_W = 16;
    localparam logic [MAX_W-1:0] MAX_RESET = 16'd32767;

    // longest held entity prefix and most characters one item can emit
    localparam int HOLD_MAX  = 4;
    localparam int MAX_CHARS = 6;

    localparam char_t CH_LT  = 8'h3C;
    localparam char_t CH_GT  = 8'h3E;
    localparam char_t CH_AMP = 8'h26;
    localparam char_t CH_NL  = 8'h0A;
    localparam char_t CH_C   = 8'h63;
    localparam char_t CH_T   = 8'h74;

    // markup literals, lower case, padded to the longest one
    localparam int LIT_DEPTH = 9;
    localparam logic [3:0] LEN_OPEN_SC  = 4'd7;
    localparam logic [3:0] LEN_OPEN_ST  = 4'd6;
    localparam logic [3:0] LEN_CLOSE_SC = 4'd9;
    localparam logic [3:0] LEN_CLOSE_ST = 4'd8;

    localparam char_t LIT_OPEN_SC [LIT_DEPTH] =
        '{8'h3C, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00, 8'h00};
    localparam char_t LIT_OPEN_ST [LIT_DEPTH] =
        '{8'h3C, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00};
    localparam char_t LIT_CLOSE_SC [LIT_DEPTH] =
        '{8'h3C, 8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3E};
    localparam char_t LIT_CLOSE_ST [LIT_DEPTH] =
        '{8'h3C, 8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h3E, 8'h00};

    // entity names without the leading ampersand
    localparam int ENT_COUNT = 6;
    localparam int ENT_NAME_LEN = 5;

    localparam char_t ENT_NAME [ENT_COUNT][ENT_NAME_LEN] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
        '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},   // nbsp;
        '{8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}    // #39;
    };
    localparam logic [2:0] ENT_LEN [ENT_COUNT] =
        '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd4};
    localparam char_t ENT_CHAR [ENT_COUNT] =
        '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20, 8'h27};

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } ent_sel_t;

    function automatic char_t to_lower(input char_t c);
        char_t r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // which entity starts with this character
    function automatic ent_sel_t entity_of(input char_t c);
        ent_sel_t r;
        r = '0;
        for (int t = 0; t < ENT_COUNT; t++)
        begin
            if (!r.hit && ENT_NAME[t][0] == c)
            begin
                r.hit = 1'b1;
                r.idx = 3'(t);
            end
        end
        return r;
    endfunction

endpackage

[design/hte_if.sv]
// handshake channels of the text extractor: body bytes, text results, cap writes
`timescale 1ns / 1ps

interface hte_body_if;
    logic           valid;
    logic           ready;
    hte_pkg::char_t body_byte;
    logic           end_of_body;

    modport source (output valid, output body_byte, output end_of_body, input ready);
    modport sink (input valid, input body_byte, input end_of_body, output ready);
endinterface

interface hte_text_if;
    logic           valid;
    logic           ready;
    hte_pkg::char_t text_char;
    logic           char_valid;
    logic           end_of_text;

    modport source (output valid, output text_char, output char_valid, output end_of_text,
                    input ready);
    modport sink (input valid, input text_char, input char_valid, input end_of_text,
                  output ready);
endinterface

interface hte_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::MAX_W-1:0]     max_output_chars;

    modport source (output valid, output max_output_chars, input ready);
    modport sink (input valid, input max_output_chars, output ready);
endinterface

[design/html_text_extractor.sv]
// html text extractor top level: tag stripping, script/style skipping, entity decode
//
// body carries one html body byte per item, end_of_body marks the final byte.
// text carries the extracted characters one per item; after the final body
// byte a closing item follows with char_valid 0 and end_of_text 1.
// cfg writes the output cap (max_output_chars) and is always ready; write it
// only while no body is in progress and all results have been taken.
// each body byte is parsed in the cycle it is accepted; its results land in a
// small result buffer and appear on text from the next cycle, one per cycle.
// a byte yields zero to seven results (an entity mismatch replays '&' and up
// to four held bytes, plus the byte itself and the closing item), so the
// buffer drain rate sets the throughput: one byte per cycle while each byte
// yields at most one result and text is ready, else body waits for the drain.
// body is ready while no result waits on text or its last result is being taken.
// when text stalls the buffered results hold and body stops taking bytes.
// reset sets the cap to 32767, clears the parser and drops pending results;
// after the final byte the parser and the character count return to reset.
`timescale 1ns / 1ps

module html_text_extractor #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    hte_body_if.sink    body,
    hte_text_if.source  text,
    hte_cfg_if.sink     cfg
);
    import hte_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > MAX_W) ? COUNT_WIDTH : MAX_W;

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_TAG,
        MODE_OPEN,
        MODE_OPEN_SC,
        MODE_OPEN_ST,
        MODE_SKIP_SC,
        MODE_SKIP_ST,
        MODE_ENTITY
    } mode_t;

    // parser state
    mode_t                  mode_reg, mode_next;
    char_t                  hold_reg [HOLD_MAX];
    char_t                  hold_next [HOLD_MAX];
    logic [2:0]             hcnt_reg, hcnt_next;
    logic [3:0]             mp_reg, mp_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   lwn_reg, lwn_next;
    logic [MAX_W-1:0]       max_reg;

    // result buffer
    char_t                  buf_reg [MAX_CHARS];
    char_t                  buf_next [MAX_CHARS];
    logic [2:0]             buf_n_reg, buf_n_next;
    logic [2:0]             rd_reg;
    logic                   end_reg;

    char_t                  c;
    char_t                  lc;
    char_t                  lit_c;
    logic [3:0]             lit_len;
    logic                   last;
    logic                   flush;
    logic                   flush_c;
    logic                   text_go;
    logic                   fin_plain;
    logic                   fin_nl;
    logic                   fin_want;
    char_t                  fin_char;
    ent_sel_t               ent_sel;
    logic [2:0]             f_len;
    logic                   lwn_mid;
    logic [CMP_W-1:0]       cnt_x, max_x, room_cap;
    logic [COUNT_WIDTH-1:0] room_lim;
    logic [2:0]             cap3, lim3, room;
    logic [2:0]             n_cand, n_emit;
    char_t                  fb [MAX_CHARS];

    logic                   body_acc;
    logic                   text_acc;
    logic                   chars_left;
    logic                   last_one;

    assign c    = body.body_byte;
    assign last = body.end_of_body;
    assign lc   = to_lower(c);

    // ---------------- byte parser ----------------
    always_comb
    begin
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        mp_next   = mp_reg;
        for (int k = 0; k < HOLD_MAX; k++)
        begin
            hold_next[k] = hold_reg[k];
        end
        flush     = 1'b0;
        flush_c   = 1'b0;
        text_go   = 1'b0;
        fin_plain = 1'b0;
        fin_nl    = 1'b0;
        fin_char  = c;
        lit_c     = LIT_OPEN_SC[mp_reg];
        lit_len   = LEN_OPEN_SC;
        ent_sel   = (hcnt_reg == 3'd0) ? entity_of(c) : entity_of(hold_reg[0]);

        case (mode_reg)
            MODE_TEXT:
            begin
                text_go = 1'b1;
            end
            MODE_TAG:
            begin
                if (c == CH_GT || last)
                begin
                    fin_nl    = 1'b1;
                    mode_next = MODE_TEXT;
                    mp_next   = 4'd0;
                end
            end
            MODE_OPEN, MODE_OPEN_SC, MODE_OPEN_ST:
            begin
                if (mode_reg == MODE_OPEN && mp_reg == 4'd2)
                begin
                    // third byte picks script or style
                    if (lc == CH_C || lc == CH_T)
                    begin
                        mode_next = (lc == CH_C) ? MODE_OPEN_SC : MODE_OPEN_ST;
                        mp_next   = 4'd3;
                        fin_nl    = last;
                    end
                    else if (c == CH_GT || last)
                    begin
                        fin_nl    = 1'b1;
                        mode_next = MODE_TEXT;
                        mp_next   = 4'd0;
                    end
                    else
                    begin
                        mode_next = MODE_TAG;
                    end
                end
                else
                begin
                    if (mode_reg == MODE_OPEN_ST)
                    begin
                        lit_c   = LIT_OPEN_ST[mp_reg];
                        lit_len = LEN_OPEN_ST;
                    end
                    if (mp_reg < lit_len && lc == lit_c)
                    begin
                        if (mp_reg + 4'd1 >= lit_len)
                        begin
                            mode_next = (mode_reg == MODE_OPEN_ST) ? MODE_SKIP_ST : MODE_SKIP_SC;
                            mp_next   = 4'd0;
                        end
                        else
                        begin
                            mp_next = mp_reg + 4'd1;
                            fin_nl  = last;
                        end
                    end
                    else if (c == CH_GT || last)
                    begin
                        fin_nl    = 1'b1;
                        mode_next = MODE_TEXT;
                        mp_next   = 4'd0;
                    end
                    else
                    begin
                        mode_next = MODE_TAG;
                        mp_next   = 4'd0;
                    end
                end
            end
            MODE_SKIP_SC, MODE_SKIP_ST:
            begin
                if (mode_reg == MODE_SKIP_ST)
                begin
                    lit_c   = LIT_CLOSE_ST[mp_reg];
                    lit_len = LEN_CLOSE_ST;
                end
                else
                begin
                    lit_c   = LIT_CLOSE_SC[mp_reg];
                    lit_len = LEN_CLOSE_SC;
                end
                if (mp_reg < lit_len && lc == lit_c)
                begin
                    if (mp_reg + 4'd1 >= lit_len)
                    begin
                        mode_next = MODE_TEXT;
                        mp_next   = 4'd0;
                    end
                    else
                    begin
                        mp_next = mp_reg + 4'd1;
                    end
                end
                else
                begin
                    mp_next = (c == CH_LT) ? 4'd1 : 4'd0;
                end
            end
            MODE_ENTITY:
            begin
                if (ent_sel.hit && hcnt_reg < ENT_LEN[ent_sel.idx] &&
                    c == ENT_NAME[ent_sel.idx][hcnt_reg])
                begin
                    if (hcnt_reg + 3'd1 == ENT_LEN[ent_sel.idx])
                    begin
                        fin_plain = 1'b1;
                        fin_char  = ENT_CHAR[ent_sel.idx];
                        hcnt_next = 3'd0;
                        mode_next = MODE_TEXT;
                    end
                    else
                    begin
                        hold_next[hcnt_reg[1:0]] = c;
                        hcnt_next = hcnt_reg + 3'd1;
                        // entity cut off by the end of the body: replay it with this byte
                        flush   = last;
                        flush_c = last;
                    end
                end
                else
                begin
                    flush   = 1'b1;
                    text_go = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_TEXT;
            end
        endcase

        if (flush)
        begin
            mode_next = MODE_TEXT;
            hcnt_next = 3'd0;
        end

        if (text_go)
        begin
            if (c == CH_LT)
            begin
                if (last)
                begin
                    fin_nl    = 1'b1;
                    mode_next = MODE_TEXT;
                    mp_next   = 4'd0;
                end
                else
                begin
                    mode_next = MODE_OPEN;
                    mp_next   = 4'd1;
                end
            end
            else if (c == CH_AMP)
            begin
                if (last)
                begin
                    fin_plain = 1'b1;
                end
                else
                begin
                    mode_next = MODE_ENTITY;
                    hcnt_next = 3'd0;
                end
            end
            else
            begin
                fin_plain = 1'b1;
            end
        end
    end

    // ---------------- emit with output cap ----------------
    always_comb
    begin
        cnt_x    = CMP_W'(cnt_reg);
        max_x    = CMP_W'(max_reg);
        room_cap = (cnt_x < max_x) ? (max_x - cnt_x) : '0;
        room_lim = ~cnt_reg;
        cap3     = (room_cap >= CMP_W'(7)) ? 3'd7 : room_cap[2:0];
        lim3     = (room_lim >= COUNT_WIDTH'(7)) ? 3'd7 : room_lim[2:0];
        room     = (cap3 < lim3) ? cap3 : lim3;

        f_len    = flush ? (3'd1 + hcnt_reg + {2'b00, flush_c}) : 3'd0;
        // replayed bytes are never newlines, so any emitted replay clears the flag
        lwn_mid  = (f_len != 3'd0 && room != 3'd0) ? 1'b0 : lwn_reg;
        fin_want = fin_plain | (fin_nl & ~lwn_mid);
        n_cand   = f_len + {2'b00, fin_want};
        n_emit   = (n_cand < room) ? n_cand : room;

        fb[0] = CH_AMP;
        for (int k = 1; k < MAX_CHARS; k++)
        begin
            fb[k] = c;
            if (k - 1 < HOLD_MAX)
            begin
                if (3'(k - 1) < hcnt_reg)
                begin
                    fb[k] = hold_reg[k - 1];
                end
            end
        end
        for (int k = 0; k < MAX_CHARS; k++)
        begin
            buf_next[k] = (3'(k) < f_len) ? fb[k] : (fin_nl ? CH_NL : fin_char);
        end
        buf_n_next = n_emit;

        if (last)
        begin
            cnt_next = '0;
            lwn_next = 1'b0;
        end
        else
        begin
            cnt_next = cnt_reg + COUNT_WIDTH'(n_emit);
            if (n_emit == 3'd0)
            begin
                lwn_next = lwn_reg;
            end
            else if (n_emit > f_len)
            begin
                lwn_next = fin_nl | (fin_char == CH_NL);
            end
            else
            begin
                lwn_next = 1'b0;
            end
        end
    end

    // ---------------- handshakes ----------------
    assign chars_left = rd_reg < buf_n_reg;
    assign last_one   = chars_left ? ((3'(rd_reg + 3'd1) == buf_n_reg) && !end_reg) : end_reg;

    assign text.valid       = chars_left | end_reg;
    assign text.text_char   = chars_left ? buf_reg[rd_reg] : 8'h00;
    assign text.char_valid  = chars_left;
    assign text.end_of_text = !chars_left && end_reg;

    assign body.ready = !text.valid || (last_one && text.ready);
    assign cfg.ready  = 1'b1;

    assign body_acc = body.valid && body.ready;
    assign text_acc = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            hcnt_reg  <= 3'd0;
            mp_reg    <= 4'd0;
            cnt_reg   <= '0;
            lwn_reg   <= 1'b0;
            max_reg   <= MAX_RESET;
            buf_n_reg <= 3'd0;
            rd_reg    <= 3'd0;
            end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_reg <= cfg.max_output_chars;
            end
            if (body_acc)
            begin
                mode_reg  <= last ? MODE_TEXT : mode_next;
                hcnt_reg  <= last ? 3'd0 : hcnt_next;
                mp_reg    <= last ? 4'd0 : mp_next;
                cnt_reg   <= cnt_next;
                lwn_reg   <= lwn_next;
                buf_n_reg <= buf_n_next;
                rd_reg    <= 3'd0;
                end_reg   <= last;
            end
            else if (text_acc)
            begin
                if (chars_left)
                begin
                    rd_reg <= rd_reg + 3'd1;
                end
                else
                begin
                    end_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (body_acc)
        begin
            for (int k = 0; k < HOLD_MAX; k++)
            begin
                hold_reg[k] <= hold_next[k];
            end
            for (int k = 0; k < MAX_CHARS; k++)
            begin
                buf_reg[k] <= buf_next[k];
            end
        end
    end

    // ---------------- checks ----------------
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= buf_n_reg && buf_n_reg <= 3'(MAX_CHARS))
        else $error("result buffer read index past fill");

    a_hold_only_in_entity: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_ENTITY |-> hcnt_reg == 3'd0)
        else $error("held entity bytes outside entity mode");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        body_acc && last |=> end_reg && mode_reg == MODE_TEXT && cnt_reg == '0 && !lwn_reg)
        else $error("final byte did not return parser to reset");

    a_skip_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SKIP_SC || mode_reg == MODE_SKIP_ST) |-> mp_reg < LEN_CLOSE_SC)
        else $error("close tag match progress out of range");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        body_acc && text.valid |-> last_one && text_acc)
        else $error("item accepted over unread results");

endmodule

[dv/hte_checker.sv]
// checker for the html text extractor: tracks parser state, predicts text items and compares
`timescale 1ns / 1ps

module hte_checker (
    input  logic clk,
    input  logic rst_n,
    hte_body_if  body,
    hte_text_if  text,
    hte_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    import hte_pkg::*;

    typedef enum logic [2:0] {
        PM_TEXT,
        PM_TAG,
        PM_OPEN,
        PM_OPEN_SC,
        PM_OPEN_ST,
        PM_SKIP_SC,
        PM_SKIP_ST,
        PM_ENTITY
    } parse_mode_e;

    typedef struct packed {
        char_t ch;
        logic  is_char;
        logic  is_end;
    } text_item_t;

    localparam int COUNT_CEIL = 65535;

    // literals right-aligned, first character in the highest used byte
    localparam logic [71:0] OPEN_SCRIPT  = "<script";
    localparam logic [71:0] OPEN_STYLE   = "<style";
    localparam logic [71:0] CLOSE_SCRIPT = "</script>";
    localparam logic [71:0] CLOSE_STYLE  = "</style>";

    text_item_t  expected_text [$];
    logic [15:0] char_cap;
    parse_mode_e mode;
    char_t       held [8];
    int          held_cnt;
    int          progress;
    int          emitted;
    logic        last_nl;

    function automatic char_t fold_case(char_t c);
        return (c >= "A" && c <= "Z") ? char_t'(c + 8'd32) : c;
    endfunction

    function automatic char_t lit_byte(logic [71:0] lit, int len, int q);
        return lit[8*(len-1-q) +: 8];
    endfunction

    function automatic int entity_len(int t);
        case (t)
            0, 5:    return 4;
            1, 2:    return 3;
            default: return 5;
        endcase
    endfunction

    function automatic logic [71:0] entity_name(int t);
        case (t)
            0:       return "amp;";
            1:       return "lt;";
            2:       return "gt;";
            3:       return "quot;";
            4:       return "nbsp;";
            default: return "#39;";
        endcase
    endfunction

    function automatic char_t entity_value(int t);
        case (t)
            0:       return "&";
            1:       return "<";
            2:       return ">";
            3:       return "\"";
            4:       return " ";
            default: return "'";
        endcase
    endfunction

    function automatic int entity_for(char_t c);
        for (int t = 0; t < 6; t++)
        begin
            if (lit_byte(entity_name(t), entity_len(t), 0) == c)
            begin
                return t;
            end
        end
        return -1;
    endfunction

    task automatic clear_parser();
        mode = PM_TEXT;
        held_cnt = 0;
        progress = 0;
        emitted = 0;
        last_nl = 1'b0;
        foreach (held[k])
        begin
            held[k] = '0;
        end
    endtask

    task automatic emit_char(char_t c);
        if (emitted >= int'(char_cap) || emitted >= COUNT_CEIL)
        begin
            return;
        end
        expected_text.push_back(text_item_t'{c, 1'b1, 1'b0});
        emitted++;
        last_nl = (c == "\n");
    endtask

    task automatic tag_break();
        if (!last_nl)
        begin
            emit_char("\n");
        end
        mode = PM_TEXT;
        progress = 0;
    endtask

    // a broken entity gives back '&' and whatever was held
    task automatic flush_held();
        emit_char("&");
        for (int k = 0; k < held_cnt; k++)
        begin
            emit_char(held[k]);
        end
        held_cnt = 0;
        mode = PM_TEXT;
    endtask

    task automatic decode_byte(char_t c, logic is_last);
        logic is_st;
        int   q;
        int   len;
        int   t;
        char_t lc;
        if (mode == PM_ENTITY)
        begin
            t = (held_cnt == 0) ? entity_for(c) : entity_for(held[0]);
            if (t >= 0 && held_cnt < entity_len(t) &&
                c == lit_byte(entity_name(t), entity_len(t), held_cnt))
            begin
                if (held_cnt + 1 == entity_len(t))
                begin
                    emit_char(entity_value(t));
                    held_cnt = 0;
                    mode = PM_TEXT;
                end
                else
                begin
                    held[held_cnt] = c;
                    held_cnt++;
                    if (is_last)
                    begin
                        flush_held();
                    end
                end
                return;
            end
            // the failing byte is parsed again as plain text
            flush_held();
        end
        case (mode)
            PM_TEXT:
            begin
                if (c == "<")
                begin
                    if (is_last)
                    begin
                        tag_break();
                    end
                    else
                    begin
                        mode = PM_OPEN;
                        progress = 1;
                    end
                end
                else if (c == "&")
                begin
                    if (is_last)
                    begin
                        emit_char("&");
                    end
                    else
                    begin
                        mode = PM_ENTITY;
                        held_cnt = 0;
                    end
                end
                else
                begin
                    emit_char(c);
                end
            end
            PM_TAG:
            begin
                if (c == ">" || is_last)
                begin
                    tag_break();
                end
            end
            PM_OPEN, PM_OPEN_SC, PM_OPEN_ST:
            begin
                q = progress;
                is_st = (mode == PM_OPEN_ST);
                // third byte picks script or style
                if (mode == PM_OPEN && q == 2)
                begin
                    lc = fold_case(c);
                    if (lc == "c")
                    begin
                        mode = PM_OPEN_SC;
                    end
                    else if (lc == "t")
                    begin
                        mode = PM_OPEN_ST;
                    end
                    else
                    begin
                        if (c == ">" || is_last)
                        begin
                            tag_break();
                        end
                        else
                        begin
                            mode = PM_TAG;
                        end
                        return;
                    end
                    progress = 3;
                    if (is_last)
                    begin
                        tag_break();
                    end
                    return;
                end
                len = is_st ? 6 : 7;
                if (q < len && fold_case(c) == lit_byte(is_st ? OPEN_STYLE : OPEN_SCRIPT, len, q))
                begin
                    q++;
                    if (q >= len)
                    begin
                        mode = is_st ? PM_SKIP_ST : PM_SKIP_SC;
                        progress = 0;
                        if (is_last)
                        begin
                            mode = PM_TEXT;
                        end
                        return;
                    end
                    progress = q;
                    if (is_last)
                    begin
                        tag_break();
                    end
                    return;
                end
                if (c == ">" || is_last)
                begin
                    tag_break();
                end
                else
                begin
                    mode = PM_TAG;
                    progress = 0;
                end
            end
            PM_SKIP_SC, PM_SKIP_ST:
            begin
                is_st = (mode == PM_SKIP_ST);
                len = is_st ? 8 : 9;
                q = progress;
                if (q < len && fold_case(c) == lit_byte(is_st ? CLOSE_STYLE : CLOSE_SCRIPT, len, q))
                begin
                    q++;
                    if (q >= len)
                    begin
                        mode = PM_TEXT;
                        q = 0;
                    end
                end
                else
                begin
                    q = (c == "<") ? 1 : 0;
                end
                progress = q;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_byte(char_t c, logic is_last);
        decode_byte(c, is_last);
        if (is_last)
        begin
            expected_text.push_back(text_item_t'{8'h00, 1'b0, 1'b1});
            clear_parser();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_item_t got;
        text_item_t want;
        if (!rst_n)
        begin
            char_cap = MAX_RESET;
            clear_parser();
            expected_text.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // results first: an item accepted now cannot have a result at this edge
            if (text.valid && text.ready)
            begin
                got = text_item_t'{text.text_char, text.char_valid, text.end_of_text};
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected text item, expected none, actual char %02h valid %0b end %0b",
                             $time, got.ch, got.is_char, got.is_end);
                    errors++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (got.ch !== want.ch || got.is_char !== want.is_char ||
                        got.is_end !== want.is_end)
                    begin
                        $display("%0t: text item mismatch, expected char %02h valid %0b end %0b, actual char %02h valid %0b end %0b",
                                 $time, want.ch, want.is_char, want.is_end,
                                 got.ch, got.is_char, got.is_end);
                        errors++;
                    end
                end
            end
            if (body.valid && body.ready)
            begin
                predict_byte(body.body_byte, body.end_of_body);
            end
            if (cfg.valid && cfg.ready)
            begin
                char_cap = cfg.max_output_chars;
            end
            pending = expected_text.size();
        end
    end

endmodule

[dv/html_text_extractor_tb.sv]
// testbench top for the html text extractor: clock, reset, body stimulus, cap writes and verdict
`timescale 1ns / 1ps

module html_text_extractor_tb;

    import hte_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic  clk;
    logic  rst_n;
    int    err_cnt;
    int    pend_cnt;
    int    cycle_cnt;
    int    byte_cnt;
    logic  quiet;
    int    hold_asks;
    int    holds_taken;
    int    hold_left;
    char_t body_bytes [$];
    string ent_names [6] = '{"amp;", "lt;", "gt;", "quot;", "nbsp;", "#39;"};

    hte_body_if body_ch ();
    hte_text_if text_ch ();
    hte_cfg_if  cfg_ch ();

    html_text_extractor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .body  (body_ch),
        .text  (text_ch),
        .cfg   (cfg_ch)
    );

    hte_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .body    (body_ch),
        .text    (text_ch),
        .cfg     (cfg_ch),
        .errors  (err_cnt),
        .pending (pend_cnt)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("html_text_extractor test failed");
            $finish;
        end
    end

    // text side: random stalls, quiet stretches, and long hold-offs on request
    initial
    begin
        text_ch.ready = 1'b0;
        holds_taken = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                text_ch.ready = 1'b0;
                hold_left--;
            end
            else if (hold_asks != holds_taken)
            begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
                text_ch.ready = 1'b0;
            end
            else if (quiet)
            begin
                text_ch.ready = 1'b1;
            end
            else
            begin
                text_ch.ready = ($urandom_range(0, 99) >= 23);
            end
        end
    end

    function automatic char_t text_byte();
        char_t c;
        if ($urandom_range(0, 7) == 0)
        begin
            return char_t'($urandom_range(0, 255));
        end
        c = char_t'($urandom_range(8'h20, 8'h7E));
        if (c == "<" || c == "&")
        begin
            c = ".";
        end
        return c;
    endfunction

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            body_bytes.push_back(s[i]);
        end
    endtask

    // markup letters in random case
    task automatic push_mixed(string s);
        char_t c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
            begin
                c = c - 8'd32;
            end
            body_bytes.push_back(c);
        end
    endtask

    task automatic add_fragment();
        string letters;
        string name;
        int    kind;
        int    n;
        int    t;
        logic  is_script;
        letters = "abcdeiprstvy";
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1, 2:
            begin
                n = $urandom_range(1, 5);
                repeat (n) body_bytes.push_back(text_byte());
            end
            3:
            begin
                body_bytes.push_back("\n");
            end
            4, 5:
            begin
                push_str("&");
                push_str(ent_names[$urandom_range(0, 5)]);
            end
            6:
            begin
                // entity prefix, then a stray byte or its next letter in random case
                name = ent_names[$urandom_range(0, 5)];
                push_str("&");
                n = $urandom_range(0, name.len() - 1);
                for (int i = 0; i < n; i++)
                begin
                    body_bytes.push_back(name[i]);
                end
                case ($urandom_range(0, 3))
                    0:       push_str("<");
                    1:       push_str("&");
                    2:       push_mixed(name.substr(n, n));
                    default: body_bytes.push_back(text_byte());
                endcase
            end
            7, 8:
            begin
                push_str("<");
                if ($urandom_range(0, 3) == 0)
                begin
                    push_str("/");
                end
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    t = $urandom_range(0, letters.len() - 1);
                    push_mixed(letters.substr(t, t));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    push_str(" x=1");
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    push_str(">");
                end
            end
            9, 10:
            begin
                is_script = 1'($urandom_range(0, 1));
                push_mixed(is_script ? "<script" : "<style");
                if ($urandom_range(0, 1) == 1)
                begin
                    push_str(" a=b");
                end
                push_str(">");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0:       body_bytes.push_back(text_byte());
                        1:       push_str("<");
                        2:       push_mixed(is_script ? "</scr" : "</sty");
                        default: push_str("&lt;x");
                    endcase
                end
                if ($urandom_range(0, 6) != 0)
                begin
                    push_mixed(is_script ? "</script>" : "</style>");
                end
            end
            default:
            begin
                body_bytes.push_back(char_t'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_byte(char_t b, logic is_last);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 23)
            begin
                body_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        body_ch.valid = 1'b1;
        body_ch.body_byte = b;
        body_ch.end_of_body = is_last;
        @(posedge clk);
        while (!body_ch.ready)
        begin
            @(posedge clk);
        end
        byte_cnt++;
        @(negedge clk);
    endtask

    task automatic send_body();
        for (int i = 0; i < body_bytes.size(); i++)
        begin
            send_byte(body_bytes[i], i == body_bytes.size() - 1);
        end
        body_ch.valid = 1'b0;
        body_bytes.delete();
    endtask

    // every text item taken, plus a margin for bytes that make none
    task automatic drain();
        while (pend_cnt != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic set_cap(logic [15:0] v);
        drain();
        cfg_ch.valid = 1'b1;
        cfg_ch.max_output_chars = v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        logic [15:0] caps [6];
        int          base;
        cycle_cnt = 0;
        byte_cnt = 0;
        quiet = 1'b0;
        hold_asks = 0;
        body_ch.valid = 1'b0;
        body_ch.body_byte = '0;
        body_ch.end_of_body = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.max_output_chars = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extreme byte values, a decoded entity, a tag, a partial entity at the end
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        push_str("&gt;<b>&am");
        send_body();
        // lone '<' as the final byte
        push_str("<");
        send_body();
        // style prefix finished by the final byte
        push_str("<StYlE");
        send_body();
        // ordinary tag left open at the end
        push_str("x<d");
        send_body();

        caps[0] = 16'hFFFF;
        caps[1] = 16'd1;
        caps[2] = 16'd0;
        caps[3] = 16'd12;
        caps[4] = 16'($urandom_range(2, 40));
        caps[5] = MAX_RESET;
        for (int p = 0; p < 6; p++)
        begin
            set_cap(caps[p]);
            quiet = (p == 3);
            if (p == 0)
            begin
                hold_asks++;
            end
            base = byte_cnt;
            while (byte_cnt - base < 12)
            begin
                repeat ($urandom_range(1, 3)) add_fragment();
                send_body();
            end
        end
        quiet = 1'b0;

        drain();
        repeat (20) @(negedge clk);
        if (err_cnt == 0)
        begin
            $display("html_text_extractor test passed");
        end
        else
        begin
            $display("html_text_extractor test failed");
        end
        $finish;
    end

endmodule
